FILE: rtl/loab_pkg.sv
// Shared types, register indexes, format codes and the divide-by-255 helper.
package loab_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_TOP    = 3'd1;
    localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_LOGO_FORMAT   = 3'd4;

    // Logo format codes
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Channel order: 0 blue, 1 green, 2 red
    typedef logic [2:0][7:0] t_bgr;

    typedef struct packed {
        logic [12:0] left;
        logic [12:0] top;
        logic [6:0]  width;
        logic [6:0]  height;
        logic [1:0]  format;
    } t_cfg;

    // Input word as unpacked from the stream
    typedef struct packed {
        logic        op;
        logic [11:0] col;
        logic [11:0] row;
        logic [11:0] idx;
        t_bgr        chan;
        logic [7:0]  alpha;
    } t_in_word;

    // Request towards the logo store stage
    typedef struct packed {
        logic       op;
        logic       wr_en;
        logic       in_win;
        t_bgr       chan;
        logic [7:0] alpha;
    } t_req;

    // Frame pixel and logo entry towards the blend stages
    typedef struct packed {
        logic        in_win;
        t_bgr        frame;
        logic [31:0] logo;
    } t_blend_in;

    // floor(n / 255) for n up to 65279
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, n} + 17'(n[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

FILE: rtl/loab_window.sv
// Window test and logo store address generation, two pipeline stages.
module loab_window import loab_pkg::*; #(
    parameter int LOGO_MAX_WIDTH  = 64,
    parameter int LOGO_MAX_HEIGHT = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output t_req             o_req,
    output logic [((LOGO_MAX_WIDTH*LOGO_MAX_HEIGHT > 1) ?
                   $clog2(LOGO_MAX_WIDTH*LOGO_MAX_HEIGHT) : 1)-1:0] o_addr
);

    localparam int DEPTH = LOGO_MAX_WIDTH * LOGO_MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (LOGO_MAX_WIDTH > 1) ? $clog2(LOGO_MAX_WIDTH) : 1;
    localparam int YW    = (LOGO_MAX_HEIGHT > 1) ? $clog2(LOGO_MAX_HEIGHT) : 1;
    localparam logic [12:0]   MAXW_C = 13'(LOGO_MAX_WIDTH);
    localparam logic [12:0]   MAXH_C = 13'(LOGO_MAX_HEIGHT);
    localparam logic [AW-1:0] MAXW_A = AW'(LOGO_MAX_WIDTH);

    // Stage A: offsets into the window and the inside test
    logic [13:0] lx_full;
    logic [13:0] ly_full;
    logic [12:0] w_lim;
    logic [12:0] h_lim;
    logic        inside_now;

    logic          r_a_valid;
    logic          r_a_op;
    logic [11:0]   r_a_idx;
    logic          r_a_inside;
    logic [XW-1:0] r_a_lx;
    logic [YW-1:0] r_a_ly;
    t_bgr          r_a_chan;
    logic [7:0]    r_a_alpha;

    // Stage B: store address
    logic          r_b_valid;
    t_req          r_b_req;
    logic [AW-1:0] r_b_addr;

    logic ready_a;
    logic ready_b;
    logic [AW-1:0] n_addr;
    logic          n_wr_en;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    // Two's complement offsets, bit 13 is the sign
    assign lx_full = {2'b00, i_word.col} - {i_cfg.left[12], i_cfg.left};
    assign ly_full = {2'b00, i_word.row} - {i_cfg.top[12], i_cfg.top};

    // Window size saturates at the store geometry
    assign w_lim = ({6'b0, i_cfg.width}  > MAXW_C) ? MAXW_C : {6'b0, i_cfg.width};
    assign h_lim = ({6'b0, i_cfg.height} > MAXH_C) ? MAXH_C : {6'b0, i_cfg.height};

    assign inside_now = !lx_full[13] && !ly_full[13] &&
                        (lx_full[12:0] < w_lim) && (ly_full[12:0] < h_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_op     <= i_word.op;
            r_a_idx    <= i_word.idx;
            r_a_inside <= inside_now;
            r_a_lx     <= lx_full[XW-1:0];
            r_a_ly     <= ly_full[YW-1:0];
            r_a_chan   <= i_word.chan;
            r_a_alpha  <= i_word.alpha;
        end
    end

    // Logo writes use their own index; writes beyond the store are dropped
    always_comb begin
        n_wr_en = r_a_op && (32'(r_a_idx) < 32'(DEPTH));
        if (r_a_op) begin
            n_addr = AW'(r_a_idx);
        end else begin
            n_addr = AW'(r_a_ly) * MAXW_A + AW'(r_a_lx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_b_req.op     <= r_a_op;
            r_b_req.wr_en  <= n_wr_en;
            r_b_req.in_win <= r_a_inside && !r_a_op;
            r_b_req.chan   <= r_a_chan;
            r_b_req.alpha  <= r_a_alpha;
            r_b_addr       <= n_addr;
        end
    end

    assign o_valid = r_b_valid;
    assign o_req   = r_b_req;
    assign o_addr  = r_b_addr;

endmodule

FILE: rtl/loab_store.sv
// Logo store: one access per word, writes and reads kept in stream order.
module loab_store import loab_pkg::*; #(
    parameter int LOGO_MAX_WIDTH  = 64,
    parameter int LOGO_MAX_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    input  logic [((LOGO_MAX_WIDTH*LOGO_MAX_HEIGHT > 1) ?
                   $clog2(LOGO_MAX_WIDTH*LOGO_MAX_HEIGHT) : 1)-1:0] i_addr,
    output logic       o_valid,
    input  logic       i_ready,
    output t_blend_in  o_data
);

    localparam int DEPTH = LOGO_MAX_WIDTH * LOGO_MAX_HEIGHT;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;
    logic        r_c_valid;
    logic        r_c_inside;
    t_bgr        r_c_frame;
    logic        ready_c;
    logic        accept;

    assign ready_c = !r_c_valid || i_ready;
    assign o_ready = ready_c;
    assign accept  = i_valid && ready_c;

    // Memory port: entry packs alpha, red, green, blue from the top byte down
    always_ff @(posedge i_clk) begin
        if (accept && i_req.wr_en) begin
            r_mem[i_addr] <= {i_req.alpha, i_req.chan[2], i_req.chan[1], i_req.chan[0]};
        end
        if (accept) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // Logo writes end here; only video pixels go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= i_valid && !i_req.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c_inside <= i_req.in_win;
            r_c_frame  <= i_req.chan;
        end
    end

    assign o_valid       = r_c_valid;
    assign o_data.in_win = r_c_inside;
    assign o_data.frame  = r_c_frame;
    assign o_data.logo   = r_rd;

    // A logo write never turns into a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.op) |=> !r_c_valid)
        else $error("logo write produced a result word");

endmodule

FILE: rtl/loab_blend.sv
// Alpha blend: products and sums, then divide by 255 and format select.
module loab_blend import loab_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_format,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_blend_in  i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_bgr       o_chan,
    output logic       o_inside
);

    // Stage D: logo*a + frame*(255-a) per channel
    logic                  r_d_valid;
    logic [2:0][15:0]      r_d_sum;
    t_bgr                  r_d_logo;
    t_bgr                  r_d_frame;
    logic                  r_d_inside;

    // Stage E: output register
    logic                  r_e_valid;
    t_bgr                  r_e_chan;
    logic                  r_e_inside;

    logic                  ready_d;
    logic                  ready_e;
    t_bgr                  logo_in;
    logic [7:0]            alpha_in;
    logic [7:0]            alpha_inv;
    logic [2:0][15:0]      n_sum;
    t_bgr                  n_chan;

    assign ready_e = !r_e_valid || i_ready;
    assign ready_d = !r_d_valid || ready_e;
    assign o_ready = ready_d;

    assign logo_in   = i_data.logo[23:0];
    assign alpha_in  = i_data.logo[31:24];
    assign alpha_inv = FULL_SCALE - alpha_in;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = ({8'b0, logo_in[c]} * {8'b0, alpha_in}) +
                       ({8'b0, i_data.frame[c]} * {8'b0, alpha_inv});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (ready_d) begin
            r_d_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_d && i_valid) begin
            r_d_sum    <= n_sum;
            r_d_logo   <= logo_in;
            r_d_frame  <= i_data.frame;
            r_d_inside <= i_data.in_win;
        end
    end

    // Colour select; an undefined format passes the frame through
    always_comb begin
        n_chan = r_d_frame;
        if (r_d_inside) begin
            case (i_format)
                FMT_GRAY: n_chan = {r_d_logo[0], r_d_logo[0], r_d_logo[0]};
                FMT_BGR:  n_chan = r_d_logo;
                FMT_BGRA: begin
                    for (int c = 0; c < 3; c++) begin
                        n_chan[c] = div255(r_d_sum[c]);
                    end
                end
                default:  n_chan = r_d_frame;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (ready_e) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_e && r_d_valid) begin
            r_e_chan   <= n_chan;
            r_e_inside <= r_d_inside;
        end
    end

    assign o_valid  = r_e_valid;
    assign o_chan   = r_e_chan;
    assign o_inside = r_e_inside;

endmodule

FILE: rtl/logo_overlay_alpha_blender_top.sv
// An accepted video pixel word passes window stages A and B, store stage C and blend stages D and E.
// Throughput: one word per cycle while the output is not stalled; the logo store takes one access per word.
// Logo write words use the same slot and give no result word.
// Reset clears the registers (window zero, format BGR) and all valid bits.
// The logo store is not cleared; entries must be written before use.
module logo_overlay_alpha_blender_top import loab_pkg::*; #(
    parameter int LOGO_MAX_WIDTH  = 64,
    parameter int LOGO_MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // col[11:0], row[23:12], store_index[35:24], blue[43:36], green[51:44],
    // red[59:52], alpha[67:60], zero pad[71:68]
    input  logic [71:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic [23:0] m_axis_tdata,
    // in_window[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int DEPTH = LOGO_MAX_WIDTH * LOGO_MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg          r_cfg;
    t_cfg          n_cfg;
    t_in_word      in_word;
    logic          win_valid;
    logic          win_ready;
    t_req          win_req;
    logic [AW-1:0] win_addr;
    logic          st_valid;
    logic          st_ready;
    t_blend_in     st_data;
    t_bgr          out_chan;
    logic          out_inside;

    // Configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LEFT:   n_cfg.left   = i_cfg_data;
                CFG_WINDOW_TOP:    n_cfg.top    = i_cfg_data;
                CFG_WINDOW_WIDTH:  n_cfg.width  = i_cfg_data[6:0];
                CFG_WINDOW_HEIGHT: n_cfg.height = i_cfg_data[6:0];
                CFG_LOGO_FORMAT:   n_cfg.format = i_cfg_data[1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= 13'd0;
            r_cfg.top    <= 13'd0;
            r_cfg.width  <= 7'd0;
            r_cfg.height <= 7'd0;
            r_cfg.format <= FMT_BGR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Unpack the input word
    assign in_word.op    = s_axis_tuser[0];
    assign in_word.col   = s_axis_tdata[11:0];
    assign in_word.row   = s_axis_tdata[23:12];
    assign in_word.idx   = s_axis_tdata[35:24];
    assign in_word.chan  = {s_axis_tdata[59:52], s_axis_tdata[51:44], s_axis_tdata[43:36]};
    assign in_word.alpha = s_axis_tdata[67:60];

    loab_window #(
        .LOGO_MAX_WIDTH  (LOGO_MAX_WIDTH),
        .LOGO_MAX_HEIGHT (LOGO_MAX_HEIGHT)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_req   (win_req),
        .o_addr  (win_addr)
    );

    loab_store #(
        .LOGO_MAX_WIDTH  (LOGO_MAX_WIDTH),
        .LOGO_MAX_HEIGHT (LOGO_MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_req   (win_req),
        .i_addr  (win_addr),
        .o_valid (st_valid),
        .i_ready (st_ready),
        .o_data  (st_data)
    );

    loab_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_format (r_cfg.format),
        .i_valid  (st_valid),
        .o_ready  (st_ready),
        .i_data   (st_data),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_chan   (out_chan),
        .o_inside (out_inside)
    );

    assign m_axis_tdata = {out_chan[2], out_chan[1], out_chan[0]};
    assign m_axis_tuser = out_inside;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // Input back-pressure only comes from a stalled, full output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // A stalled pipeline keeps its result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> m_axis_tvalid)
        else $error("result word lost under back-pressure");

endmodule
